// File: design/mwsm_pkg.sv
// shared types and constants for the multiword schoolbook multiplier
// request and result structs, sequencer states, control bundles
// no dependencies
package mwsm_pkg;

	localparam int WORD_BITS     = 32;
	localparam int MAX_WORDS_DEF = 16;

	localparam logic FUNC_A = 1'b0;
	localparam logic FUNC_B = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [WORD_BITS-1:0] word;
		logic                 last_word;
	} req_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] product_word;
		logic                 product_last;
		logic                 length_overflow;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_ACC,
		ST_CARRY,
		ST_OUT
	} state_t;

	// controls for the multiply-accumulate unit and the product store
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic use_acc;
		logic carry_clr;
		logic p_we;
		logic p_wcarry;
	} mac_ctl_t;

	// result word on its way from the product store read to the output register
	typedef struct packed {
		logic valid;
		logic last;
		logic zero;
		logic ovf;
	} emit_t;

endpackage

// File: design/mwsm_mac.sv
// shared digit-step unit: registered word multiply, then add of stored word and carry
// keeps the running carry of the current row
// depends on mwsm_pkg
module mwsm_mac (
	input  logic                          clk,
	input  mwsm_pkg::mac_ctl_t            ctl,
	input  logic [mwsm_pkg::WORD_BITS-1:0] a,
	input  logic [mwsm_pkg::WORD_BITS-1:0] b,
	input  logic [mwsm_pkg::WORD_BITS-1:0] acc,
	output logic [mwsm_pkg::WORD_BITS-1:0] lo,
	output logic [mwsm_pkg::WORD_BITS-1:0] carry
);

	localparam int W = mwsm_pkg::WORD_BITS;

	logic [2*W-1:0] prod_s1;
	logic [2*W-1:0] sum;
	logic [W-1:0]   acc_sel;
	logic [W-1:0]   carry_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= (2*W)'(a) * (2*W)'(b);
		end
	end

	// first row of the product starts from an empty store
	assign acc_sel = ctl.use_acc ? acc : '0;
	// a*b + acc + carry never exceeds two words
	assign sum     = prod_s1 + (2*W)'(acc_sel) + (2*W)'(carry_q);

	always_ff @(posedge clk) begin
		if (ctl.carry_clr) begin
			carry_q <= '0;
		end else if (ctl.acc_en) begin
			carry_q <= sum[2*W-1:W];
		end
	end

	assign lo    = sum[W-1:0];
	assign carry = carry_q;

endmodule

// File: design/mwsm_ctrl.sv
// sequencer: operand word counts, digit loop over rows and columns, result drain
// drives store addresses and the digit-step unit controls
// depends on mwsm_pkg
module mwsm_ctrl #(
	parameter int MAX_WORDS = mwsm_pkg::MAX_WORDS_DEF,
	parameter int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
	parameter int PW        = $clog2(2 * MAX_WORDS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mwsm_pkg::req_t     req,
	output logic               busy,
	output logic               a_we,
	output logic               b_we,
	output logic [AW-1:0]      a_waddr,
	output logic [AW-1:0]      b_waddr,
	output logic [AW-1:0]      a_raddr,
	output logic [AW-1:0]      b_raddr,
	output logic [PW-1:0]      p_raddr,
	output logic [PW-1:0]      p_waddr,
	output mwsm_pkg::mac_ctl_t ctl,
	output mwsm_pkg::emit_t    emit_s1
);

	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam int TW = $clog2(2 * MAX_WORDS + 1);

	mwsm_pkg::state_t state_q, state_nxt;

	logic [CW-1:0] ca_q, cb_q;
	logic          ovf_q;
	logic [AW-1:0] i_q, j_q;
	logic [PW-1:0] k_q;
	logic [TW-1:0] total;
	logic          accept;
	logic          a_room, b_room;
	logic          row_end, col_end, out_end;

	assign accept  = start && !busy;
	assign a_room  = ca_q < CW'(MAX_WORDS);
	assign b_room  = cb_q < CW'(MAX_WORDS);
	assign total   = TW'(ca_q) + TW'(cb_q);
	assign row_end = CW'(i_q) == ca_q - CW'(1);
	assign col_end = CW'(j_q) == cb_q - CW'(1);
	assign out_end = TW'(k_q) == total - TW'(1);

	assign busy = (state_q != mwsm_pkg::ST_IDLE) || emit_s1.valid;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mwsm_pkg::ST_IDLE: begin
				if (accept && req.func == mwsm_pkg::FUNC_B && req.last_word) begin
					state_nxt = (ca_q == '0) ? mwsm_pkg::ST_OUT : mwsm_pkg::ST_RD;
				end
			end
			mwsm_pkg::ST_RD:    state_nxt = mwsm_pkg::ST_MUL;
			mwsm_pkg::ST_MUL:   state_nxt = mwsm_pkg::ST_ACC;
			mwsm_pkg::ST_ACC:   state_nxt = row_end ? mwsm_pkg::ST_CARRY : mwsm_pkg::ST_RD;
			mwsm_pkg::ST_CARRY: state_nxt = col_end ? mwsm_pkg::ST_OUT : mwsm_pkg::ST_RD;
			mwsm_pkg::ST_OUT:   state_nxt = out_end ? mwsm_pkg::ST_IDLE : mwsm_pkg::ST_OUT;
			default:            state_nxt = mwsm_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl     = '0;
		a_we    = 1'b0;
		b_we    = 1'b0;
		p_raddr = PW'(i_q) + PW'(j_q);
		p_waddr = PW'(i_q) + PW'(j_q);
		unique case (state_q)
			mwsm_pkg::ST_IDLE: begin
				ctl.carry_clr = 1'b1;
				a_we = accept && req.func == mwsm_pkg::FUNC_A && a_room;
				b_we = accept && req.func == mwsm_pkg::FUNC_B && b_room;
			end
			mwsm_pkg::ST_RD: begin
			end
			mwsm_pkg::ST_MUL: begin
				ctl.mul_en = 1'b1;
			end
			mwsm_pkg::ST_ACC: begin
				ctl.acc_en  = 1'b1;
				ctl.use_acc = j_q != '0;
				ctl.p_we    = 1'b1;
			end
			mwsm_pkg::ST_CARRY: begin
				// final carry of the row lands just above its top digit
				ctl.p_we      = 1'b1;
				ctl.p_wcarry  = 1'b1;
				ctl.carry_clr = 1'b1;
				p_waddr       = PW'(j_q) + PW'(ca_q);
			end
			mwsm_pkg::ST_OUT: begin
				p_raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	assign a_waddr = ca_q[AW-1:0];
	assign b_waddr = cb_q[AW-1:0];
	assign a_raddr = i_q;
	assign b_raddr = j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mwsm_pkg::ST_IDLE;
			ca_q    <= '0;
			cb_q    <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			emit_s1 <= '0;
		end else begin
			state_q       <= state_nxt;
			emit_s1.valid <= state_q == mwsm_pkg::ST_OUT;
			unique case (state_q)
				mwsm_pkg::ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
					if (accept) begin
						if (req.func == mwsm_pkg::FUNC_A) begin
							if (a_room) begin
								ca_q <= ca_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end else begin
							if (b_room) begin
								cb_q <= cb_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				mwsm_pkg::ST_ACC: begin
					if (!row_end) begin
						i_q <= i_q + AW'(1);
					end
				end
				mwsm_pkg::ST_CARRY: begin
					i_q <= '0;
					if (!col_end) begin
						j_q <= j_q + AW'(1);
					end
				end
				mwsm_pkg::ST_OUT: begin
					k_q          <= k_q + PW'(1);
					emit_s1.last <= out_end;
					emit_s1.zero <= ca_q == '0;
					emit_s1.ovf  <= ovf_q;
					if (out_end) begin
						ca_q  <= '0;
						cb_q  <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/multiword_schoolbook_multiplier.sv
// Unsigned multi-word multiplier, operand scanning. Send the words of A, then of B, each least
// significant first, one request per cycle while busy is low. A B request with last_word set
// starts the product: every digit step of the shared 32x32 multiply-accumulate unit runs a
// store read, a multiply, then an add and write back, and each row of A ends with one carry
// write; when A is empty the digit steps are skipped. Then the ca+cb product words, with ca
// and cb the held word counts, stream out on done/res, one per cycle in consecutive cycles,
// least significant first, the last marked by product_last. The receiver cannot hold results
// off. busy stays high from the last B word until the final read of the product store has
// left for the output register. Words beyond MAX_WORDS per operand are dropped and flagged on
// length_overflow for every word of that product.
// depends on mwsm_pkg, mwsm_mac, mwsm_ctrl
module multiword_schoolbook_multiplier #(
	parameter int MAX_WORDS = mwsm_pkg::MAX_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  mwsm_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output mwsm_pkg::res_t res
);

	localparam int W  = mwsm_pkg::WORD_BITS;
	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int PW = $clog2(2 * MAX_WORDS);
	localparam int PD = 2 * MAX_WORDS;

	logic [W-1:0] a_mem [MAX_WORDS];
	logic [W-1:0] b_mem [MAX_WORDS];
	logic [W-1:0] p_mem [PD];

	logic               a_we, b_we;
	logic [AW-1:0]      a_waddr, b_waddr, a_raddr, b_raddr;
	logic [PW-1:0]      p_raddr, p_waddr;
	logic [W-1:0]       a_rd_q, b_rd_q, p_rd_q;
	logic [W-1:0]       mac_lo, mac_carry, p_wdata;
	mwsm_pkg::mac_ctl_t ctl;
	mwsm_pkg::emit_t    emit_s1;
	logic               done_q;
	mwsm_pkg::res_t     res_q;

	mwsm_ctrl #(
		.MAX_WORDS (MAX_WORDS),
		.AW        (AW),
		.PW        (PW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.a_we    (a_we),
		.b_we    (b_we),
		.a_waddr (a_waddr),
		.b_waddr (b_waddr),
		.a_raddr (a_raddr),
		.b_raddr (b_raddr),
		.p_raddr (p_raddr),
		.p_waddr (p_waddr),
		.ctl     (ctl),
		.emit_s1 (emit_s1)
	);

	mwsm_mac u_mac (
		.clk   (clk),
		.ctl   (ctl),
		.a     (a_rd_q),
		.b     (b_rd_q),
		.acc   (p_rd_q),
		.lo    (mac_lo),
		.carry (mac_carry)
	);

	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[a_waddr] <= req.word;
		end
		a_rd_q <= a_mem[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[b_waddr] <= req.word;
		end
		b_rd_q <= b_mem[b_raddr];
	end

	assign p_wdata = ctl.p_wcarry ? mac_carry : mac_lo;

	always_ff @(posedge clk) begin
		if (ctl.p_we) begin
			p_mem[p_waddr] <= p_wdata;
		end
		p_rd_q <= p_mem[p_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit_s1.valid;
		end
	end

	// with an empty A the store was never written for this product
	always_ff @(posedge clk) begin
		if (emit_s1.valid) begin
			res_q.product_word    <= emit_s1.zero ? '0 : p_rd_q;
			res_q.product_last    <= emit_s1.last;
			res_q.length_overflow <= emit_s1.ovf;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
